// ----- rtl/core/pcxrle_pkg.sv -----
// Package with shared types, constants and helpers of the PCX run-length line encoder.
`default_nettype none
package pcxrle_pkg;

  localparam logic [5:0] RunMax     = 6'd63;
  localparam logic [7:0] LiteralMax = 8'h3F;
  localparam logic [1:0] CountTag   = 2'b11;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] value;
    logic [5:0] length;
  } run_t;

  // Work for the back end caused by one input transfer: the run that the byte
  // closed, and the run that the end of the line closed.
  typedef struct packed {
    logic  prev_vld;
    run_t  prev_run;
    logic  line_vld;
    run_t  line_run;
  } job_t;

  function automatic logic needs_count(run_t r);
    needs_count = (r.length > 6'd1) || (r.value > LiteralMax);
  endfunction

  function automatic logic [7:0] count_byte(run_t r);
    count_byte = {CountTag, r.length};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pcx_rle_line_encoder.sv -----
// Top level of the PCX run-length line encoder: front end, job queue and back end.
// A closed run is queued as a job; its first code byte is then registered in the output stage.
// Throughput: one input byte per cycle unless the queue is full; the back end sends one code
// byte per cycle unless stalled, and an item yields zero to four code bytes, two for distinct
// bytes above 0x3F. The single-byte output register of the back end sets the sustained rate.
// Reset clears the pending run, empties the queue and drops any held output byte.
`default_nettype none
module pcx_rle_line_encoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] pixel_byte_i,
  input  wire logic       line_last_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      code_byte_o,
  output logic            item_last_o,
  output logic            line_end_o
);

  // The front end decides on each transfer which runs close. Every transfer that
  // closes at least one run pushes one job: the run that the new byte ended, the
  // run that the end of the line ended, or both.
  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             pop;
  pcxrle_pkg::job_t push_job;
  pcxrle_pkg::job_t head_job;

  pcxrle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_byte_i (pixel_byte_i),
    .line_last_i  (line_last_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  // The queue lets the front end keep taking bytes while the back end is held
  // by a stalled output.
  pcxrle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (head_job),
    .pop_i   (pop)
  );

  // The back end turns each job into its count and data bytes, one per cycle while the
  // output is not stalled, and marks the last byte of the job and the last byte of the line.
  pcxrle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_byte_o (code_byte_o),
    .item_last_o (item_last_o),
    .line_end_o  (line_end_o)
  );

endmodule
`default_nettype wire

// ----- rtl/core/pcxrle_front.sv -----
// Front end: accepts pixel bytes, tracks the pending run and issues close jobs.
`default_nettype none
module pcxrle_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        pixel_byte_i,
  input  wire logic              line_last_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output pcxrle_pkg::job_t       job_o
);

  logic [7:0] run_value_q, run_value_d;
  logic [5:0] run_length_q, run_length_d;
  logic       accept;
  logic       close_prev;
  logic [7:0] new_value;
  logic [5:0] new_length;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    close_prev = (run_length_q != 6'd0) &&
                 ((pixel_byte_i != run_value_q) || (run_length_q >= pcxrle_pkg::RunMax));
    if (close_prev || (run_length_q == 6'd0)) begin
      new_value  = pixel_byte_i;
      new_length = 6'd1;
    end else begin
      new_value  = run_value_q;
      new_length = run_length_q + 6'd1;
    end

    job_o.prev_vld        = close_prev;
    job_o.prev_run.value  = run_value_q;
    job_o.prev_run.length = run_length_q;
    job_o.line_vld        = line_last_i;
    job_o.line_run.value  = new_value;
    job_o.line_run.length = new_length;

    push_o = accept && (close_prev || line_last_i);

    run_value_d  = run_value_q;
    run_length_d = run_length_q;
    if (accept) begin
      run_value_d  = new_value;
      run_length_d = line_last_i ? 6'd0 : new_length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_value_q  <= 8'd0;
      run_length_q <= 6'd0;
    end else begin
      run_value_q  <= run_value_d;
      run_length_q <= run_length_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pcxrle_queue.sv -----
// Two-entry job queue between the front end and the back end.
`default_nettype none
module pcxrle_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire pcxrle_pkg::job_t  job_i,
  output logic                   full_o,
  output logic                   valid_o,
  output pcxrle_pkg::job_t       job_o,
  input  wire logic              pop_i
);

  pcxrle_pkg::job_t slot_q [pcxrle_pkg::QueueDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'(pcxrle_pkg::QueueDepth));
  assign valid_o = (count_q != 2'd0);
  assign job_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pcxrle_back.sv -----
// Back end: walks the bytes of the head job into a registered output stage.
`default_nettype none
module pcxrle_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire pcxrle_pkg::job_t  job_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [7:0]             code_byte_o,
  output logic                   item_last_o,
  output logic                   line_end_o
);

  logic [1:0] pos_q, pos_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] code_q, code_d;
  logic       item_last_q, item_last_d;
  logic       line_end_q, line_end_d;
  logic       load;
  logic       cnt_prev, cnt_line;
  logic [1:0] n_prev, n_line, total, rel;
  logic [7:0] cur_byte;
  logic       cur_last;

  always_comb begin
    cnt_prev = pcxrle_pkg::needs_count(job_i.prev_run);
    cnt_line = pcxrle_pkg::needs_count(job_i.line_run);
    n_prev   = job_i.prev_vld ? (cnt_prev ? 2'd2 : 2'd1) : 2'd0;
    n_line   = job_i.line_vld ? (cnt_line ? 2'd2 : 2'd1) : 2'd0;
    // A job holds at most four bytes, so the sum minus one fits two bits.
    total    = n_prev + n_line - 2'd1;
    rel      = pos_q - n_prev;

    if (pos_q < n_prev) begin
      cur_byte = (pos_q == 2'd0 && cnt_prev) ? pcxrle_pkg::count_byte(job_i.prev_run)
                                             : job_i.prev_run.value;
    end else begin
      cur_byte = (rel == 2'd0 && cnt_line) ? pcxrle_pkg::count_byte(job_i.line_run)
                                           : job_i.line_run.value;
    end
    cur_last = (pos_q == total);

    load  = !out_valid_q || !out_stall_i;
    pop_o = load && q_valid_i && cur_last;

    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    code_d      = code_q;
    item_last_d = item_last_q;
    line_end_d  = line_end_q;
    if (load) begin
      out_valid_d = q_valid_i;
      if (q_valid_i) begin
        code_d      = cur_byte;
        item_last_d = cur_last;
        line_end_d  = cur_last && job_i.line_vld;
        pos_d       = cur_last ? 2'd0 : pos_q + 2'd1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign code_byte_o = code_q;
  assign item_last_o = item_last_q;
  assign line_end_o  = line_end_q;

  always_ff @(posedge clk_i) begin
    code_q      <= code_d;
    item_last_q <= item_last_d;
    line_end_q  <= line_end_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire
